// ===== hdl/mi4_pkg.sv =====
// mi4_pkg: shared types, constants and operand planning for the 4x4 matrix inverse.
// Used by mi4_ram and matrix_inverse_4x4; depends on nothing.
package mi4_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DIGIT_WIDTH     = 16;
   localparam int ELEM_DEPTH      = 16;
   localparam int WORK_DEPTH      = 28;

   localparam logic [3:0] LAST_INDEX  = 4'd15;
   localparam logic [3:0] LAST_MINOR  = 4'd11;
   localparam logic [3:0] MINOR_SPLIT = 4'd6;
   localparam logic [4:0] MINOR_BASE  = 5'd16;
   localparam logic [4:0] MINOR_GROUP = 5'd6;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_A,
      ST_RD_B,
      ST_LD_V,
      ST_MUL,
      ST_ACC,
      ST_WR,
      ST_DPREP,
      ST_DRND,
      ST_DRD,
      ST_DLD,
      ST_DCHK,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_MINOR,
      KIND_COF,
      KIND_DET
   } kind_type;

   typedef struct packed {
      logic [3:0] elem_addr;
      logic [4:0] opnd_addr;
      logic       opnd_elem;
      logic       negate;
   } term_type;

   // column pair (a < b) to minor slot
   function automatic logic [2:0] pair_index(logic [1:0] a, logic [1:0] b);
      logic [2:0] p;
      case ({a, b})
         4'b0001: p = 3'd0;
         4'b0010: p = 3'd1;
         4'b0011: p = 3'd2;
         4'b0110: p = 3'd3;
         4'b0111: p = 3'd4;
         4'b1011: p = 3'd5;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic term_last(kind_type kind, logic [1:0] term);
      logic l;
      case (kind)
         KIND_MINOR: l = (term == 2'd1);
         KIND_COF:   l = (term == 2'd2);
         KIND_DET:   l = (term == 2'd3);
         default:    l = 1'b1;
      endcase
      return l;
   endfunction

   // Minors: rows 0/1 at slots 0..5, rows 2/3 at 6..11.
   // Cofactor rows 0,1 expand on their first remaining row with rows 2/3 minors,
   // rows 2,3 on their last remaining row with rows 0/1 minors.
   function automatic term_type plan_term(kind_type kind, logic [3:0] idx, logic [1:0] term);
      term_type   t;
      logic [1:0] rt, ru, ca, cb, r, c, er, jk, x, y, c0, c1, c2;
      logic [2:0] mi;
      t  = '0;
      rt = 2'd0; ru = 2'd1; ca = 2'd0; cb = 2'd1;
      r  = idx[3:2]; c = idx[1:0];
      er = 2'd0; jk = 2'd0; x = 2'd0; y = 2'd0;
      c0 = (c == 2'd0) ? 2'd1 : 2'd0;
      c1 = (c <= 2'd1) ? 2'd2 : 2'd1;
      c2 = (c <= 2'd2) ? 2'd3 : 2'd2;
      if (idx >= MINOR_SPLIT) begin
         mi = 3'(idx - MINOR_SPLIT);
      end else begin
         mi = idx[2:0];
      end
      case (kind)
         KIND_MINOR: begin
            if (idx >= MINOR_SPLIT) begin
               rt = 2'd2; ru = 2'd3;
            end
            case (mi)
               3'd0:    begin ca = 2'd0; cb = 2'd1; end
               3'd1:    begin ca = 2'd0; cb = 2'd2; end
               3'd2:    begin ca = 2'd0; cb = 2'd3; end
               3'd3:    begin ca = 2'd1; cb = 2'd2; end
               3'd4:    begin ca = 2'd1; cb = 2'd3; end
               default: begin ca = 2'd2; cb = 2'd3; end
            endcase
            t.opnd_elem = 1'b1;
            if (term == 2'd0) begin
               t.elem_addr = {rt, ca};
               t.opnd_addr = {1'b0, ru, cb};
               t.negate    = 1'b0;
            end else begin
               t.elem_addr = {rt, cb};
               t.opnd_addr = {1'b0, ru, ca};
               t.negate    = 1'b1;
            end
         end
         KIND_COF: begin
            case (term)
               2'd0:    begin jk = c0; x = c1; y = c2; end
               2'd1:    begin jk = c1; x = c0; y = c2; end
               default: begin jk = c2; x = c0; y = c1; end
            endcase
            case (r)
               2'd0:    er = 2'd1;
               2'd1:    er = 2'd0;
               2'd2:    er = 2'd3;
               default: er = 2'd2;
            endcase
            t.elem_addr = {er, jk};
            t.opnd_addr = MINOR_BASE + (r[1] ? 5'd0 : MINOR_GROUP) + 5'(pair_index(x, y));
            t.opnd_elem = 1'b0;
            t.negate    = r[0] ^ c[0] ^ term[0];
         end
         KIND_DET: begin
            t.elem_addr = {2'd0, term};
            t.opnd_addr = {3'd0, term};
            t.opnd_elem = 1'b0;
            t.negate    = 1'b0;
         end
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== hdl/mi4_ram.sv =====
// mi4_ram: generic single-write, single-read synchronous RAM with registered read.
// Depends on mi4_pkg for default sizes.
module mi4_ram #(
   parameter int WIDTH = mi4_pkg::VALUE_WIDTH_DEF,
   parameter int DEPTH = mi4_pkg::ELEM_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/matrix_inverse_4x4.sv =====
// matrix_inverse_4x4: fixed-point 4x4 inverse by adjugate and determinant.
// Depends on mi4_pkg and mi4_ram (element store and minor/cofactor store).
//
// Input channel req_*: sixteen elements, row-major; each accepted transaction
// is written to the element store. The sixteenth starts the computation and
// req_stall stays high until the last result has been loaded into the output
// register. Result channel rsp_*: sixteen transactions in row-major order,
// each with the determinant and flags, rsp_last on the sixteenth.
// Computation: 12 minors, 16 cofactors and the determinant run on one shared
// VALUE_WIDTH x 16 multiplier, one operand digit per cycle; each term reads
// its two operands, multiplies digit by digit and accumulates. Each entry
// then goes through the restoring divider, one quotient bit per cycle.
// A stalled receiver holds the output register and the divider waits; the
// next matrix may load while the last result is pending.
// Reset clears the load count, the sequencer and rsp_valid; the stores need
// no clearing.
module matrix_inverse_4x4 #(
   parameter int VALUE_WIDTH = mi4_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_element_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_inverse_value,
   output logic [3:0]             rsp_element_index,
   output logic [VALUE_WIDTH-1:0] rsp_determinant,
   output logic                   rsp_singular,
   output logic                   rsp_saturated,
   output logic                   rsp_last
);

   localparam int W        = VALUE_WIDTH;
   localparam int F        = FRAC_BITS;
   localparam int DG       = mi4_pkg::DIGIT_WIDTH;
   localparam int CW       = 3 * W + 1;
   localparam int AW       = 4 * W + 2;
   localparam int ND_MINOR = (W + DG - 1) / DG;
   localparam int ND_COF   = (2 * W + DG - 1) / DG;
   localparam int ND_DET   = (CW + DG - 1) / DG;
   localparam int VPAD     = ND_DET * DG;
   localparam int DCW      = $clog2(ND_DET);
   localparam int NSH      = 2 * F + 1;
   localparam int NW       = ((AW > CW + NSH) ? AW : CW + NSH) + 1;
   localparam int RW       = (NW > AW + W + 1) ? NW : AW + W + 1;
   localparam int BCW      = $clog2(W);

   mi4_pkg::state_type state_ff, state_in;
   mi4_pkg::kind_type  kind_ff, kind_in;
   mi4_pkg::term_type  plan;

   logic [3:0]      load_count_ff, load_count_in;
   logic [3:0]      idx_ff, idx_in;
   logic [1:0]      term_ff, term_in;
   logic [DCW-1:0]  dcnt_ff, dcnt_in, nd_last;
   logic [W-1:0]    emag_ff, emag_in;
   logic            esign_ff, esign_in;
   logic [VPAD-1:0] vmag_ff, vmag_in;
   logic            vsign_ff, vsign_in;
   logic [AW-1:0]   prod_ff, prod_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]   det_ff, det_in;
   logic [AW-1:0]   dmag_ff, dmag_in;
   logic            dneg_ff, dneg_in;
   logic            singular_ff, singular_in;
   logic [W-1:0]    det_out_ff, det_out_in;
   logic            det_clip_ff, det_clip_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [RW-1:0]   dsh_ff, dsh_in;
   logic [W-1:0]    q_ff, q_in;
   logic [BCW-1:0]  bcnt_ff, bcnt_in;
   logic            ovf_ff, ovf_in;
   logic            qneg_ff, qneg_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    rsp_inverse_ff, rsp_inverse_in;
   logic [3:0]      rsp_index_ff, rsp_index_in;
   logic [W-1:0]    rsp_det_ff, rsp_det_in;
   logic            rsp_singular_ff, rsp_singular_in;
   logic            rsp_saturated_ff, rsp_saturated_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_accept, rsp_load, last_term, ovf_now;
   logic            elem_wr_en, work_wr_en;
   logic [3:0]      elem_wr_addr, elem_rd_addr;
   logic [4:0]      work_wr_addr, work_rd_addr;
   logic [W-1:0]    elem_rdata;
   logic [CW-1:0]   work_rdata, operand, cof_mag;
   logic [DG-1:0]   digit;
   logic [W+DG-1:0] partial;
   logic [AW-1:0]   half, det_round, det_lim;
   logic [W-1:0]    lim_det, lim_q, mag_q, val_q;
   logic            clip_q;

   assign req_stall  = (state_ff != mi4_pkg::ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == mi4_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign plan      = mi4_pkg::plan_term(kind_ff, idx_ff, term_ff);
   assign last_term = mi4_pkg::term_last(kind_ff, term_ff);

   always_comb begin
      case (kind_ff)
         mi4_pkg::KIND_MINOR: nd_last = DCW'(ND_MINOR - 1);
         mi4_pkg::KIND_COF:   nd_last = DCW'(ND_COF - 1);
         default:             nd_last = DCW'(ND_DET - 1);
      endcase
   end

   assign digit   = vmag_ff[dcnt_ff * DG +: DG];
   assign partial = emag_ff * digit;

   assign operand = plan.opnd_elem ? {{(CW - W){elem_rdata[W-1]}}, elem_rdata} : work_rdata;
   assign cof_mag = work_rdata[CW-1] ? (~work_rdata + 1'b1) : work_rdata;

   assign half      = {{(AW - 1){1'b0}}, 1'b1} << (3 * F - 1);
   assign det_round = (dmag_ff + half) >> (3 * F);
   assign lim_det   = dneg_ff ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
   assign det_lim   = {{(AW - W){1'b0}}, lim_det};

   assign ovf_now = rem_ff >= ({{(RW - AW){1'b0}}, dmag_ff} << (W + 1));

   assign lim_q  = qneg_ff ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
   assign clip_q = ovf_ff || (q_ff > lim_q);
   assign mag_q  = clip_q ? lim_q : q_ff;
   assign val_q  = qneg_ff ? (~mag_q + 1'b1) : mag_q;

   // store ports
   assign elem_wr_en   = req_accept;
   assign elem_wr_addr = load_count_ff;
   assign elem_rd_addr = (state_ff == mi4_pkg::ST_RD_B) ? plan.opnd_addr[3:0] : plan.elem_addr;
   assign work_wr_en   = (state_ff == mi4_pkg::ST_WR) && (kind_ff != mi4_pkg::KIND_DET);
   assign work_wr_addr = (kind_ff == mi4_pkg::KIND_MINOR) ?
                         (mi4_pkg::MINOR_BASE + {1'b0, idx_ff}) : {1'b0, idx_ff};
   assign work_rd_addr = (state_ff == mi4_pkg::ST_DRD) ?
                         {1'b0, idx_ff[1:0], idx_ff[3:2]} : plan.opnd_addr;

   mi4_ram #(
      .WIDTH (W),
      .DEPTH (mi4_pkg::ELEM_DEPTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (req_element_value),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rdata)
   );

   mi4_ram #(
      .WIDTH (CW),
      .DEPTH (mi4_pkg::WORK_DEPTH)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_wr_en),
      .wr_addr (work_wr_addr),
      .wr_data (acc_ff[CW-1:0]),
      .rd_addr (work_rd_addr),
      .rd_data (work_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mi4_pkg::ST_LOAD: begin
            if (req_accept && (load_count_ff == mi4_pkg::LAST_INDEX)) begin
               state_in = mi4_pkg::ST_RD_A;
            end
         end
         mi4_pkg::ST_RD_A: state_in = mi4_pkg::ST_RD_B;
         mi4_pkg::ST_RD_B: state_in = mi4_pkg::ST_LD_V;
         mi4_pkg::ST_LD_V: state_in = mi4_pkg::ST_MUL;
         mi4_pkg::ST_MUL: begin
            if (dcnt_ff == '0) begin
               state_in = mi4_pkg::ST_ACC;
            end
         end
         mi4_pkg::ST_ACC: state_in = last_term ? mi4_pkg::ST_WR : mi4_pkg::ST_RD_A;
         mi4_pkg::ST_WR: begin
            state_in = (kind_ff == mi4_pkg::KIND_DET) ? mi4_pkg::ST_DPREP : mi4_pkg::ST_RD_A;
         end
         mi4_pkg::ST_DPREP: state_in = mi4_pkg::ST_DRND;
         mi4_pkg::ST_DRND:  state_in = mi4_pkg::ST_DRD;
         mi4_pkg::ST_DRD:   state_in = mi4_pkg::ST_DLD;
         mi4_pkg::ST_DLD:   state_in = mi4_pkg::ST_DCHK;
         mi4_pkg::ST_DCHK: begin
            state_in = (singular_ff || ovf_now) ? mi4_pkg::ST_OUT : mi4_pkg::ST_DIV;
         end
         mi4_pkg::ST_DIV: begin
            if (bcnt_ff == '0) begin
               state_in = mi4_pkg::ST_OUT;
            end
         end
         mi4_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = (idx_ff == mi4_pkg::LAST_INDEX) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_DRD;
            end
         end
         default: state_in = mi4_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      load_count_in    = load_count_ff;
      kind_in          = kind_ff;
      idx_in           = idx_ff;
      term_in          = term_ff;
      dcnt_in          = dcnt_ff;
      emag_in          = emag_ff;
      esign_in         = esign_ff;
      vmag_in          = vmag_ff;
      vsign_in         = vsign_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      det_in           = det_ff;
      dmag_in          = dmag_ff;
      dneg_in          = dneg_ff;
      singular_in      = singular_ff;
      det_out_in       = det_out_ff;
      det_clip_in      = det_clip_ff;
      rem_in           = rem_ff;
      dsh_in           = dsh_ff;
      q_in             = q_ff;
      bcnt_in          = bcnt_ff;
      ovf_in           = ovf_ff;
      qneg_in          = qneg_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_inverse_in   = rsp_inverse_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_det_in       = rsp_det_ff;
      rsp_singular_in  = rsp_singular_ff;
      rsp_saturated_in = rsp_saturated_ff;
      rsp_last_in      = rsp_last_ff;

      if (req_accept) begin
         load_count_in = load_count_ff + 4'd1;
      end

      case (state_ff)
         mi4_pkg::ST_LOAD: begin
            acc_in  = '0;
            kind_in = mi4_pkg::KIND_MINOR;
            idx_in  = 4'd0;
            term_in = 2'd0;
         end
         mi4_pkg::ST_RD_B: begin
            esign_in = elem_rdata[W-1];
            emag_in  = elem_rdata[W-1] ? (~elem_rdata + 1'b1) : elem_rdata;
         end
         mi4_pkg::ST_LD_V: begin
            vsign_in = operand[CW-1];
            vmag_in  = {{(VPAD - CW){1'b0}}, operand[CW-1] ? (~operand + 1'b1) : operand};
            prod_in  = '0;
            dcnt_in  = nd_last;
         end
         mi4_pkg::ST_MUL: begin
            prod_in = (prod_ff << DG) + {{(AW - W - DG){1'b0}}, partial};
            dcnt_in = dcnt_ff - 1'b1;
         end
         mi4_pkg::ST_ACC: begin
            acc_in  = (esign_ff ^ vsign_ff ^ plan.negate) ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
            term_in = term_ff + 2'd1;
         end
         mi4_pkg::ST_WR: begin
            acc_in  = '0;
            term_in = 2'd0;
            case (kind_ff)
               mi4_pkg::KIND_MINOR: begin
                  if (idx_ff == mi4_pkg::LAST_MINOR) begin
                     kind_in = mi4_pkg::KIND_COF;
                     idx_in  = 4'd0;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               mi4_pkg::KIND_COF: begin
                  if (idx_ff == mi4_pkg::LAST_INDEX) begin
                     kind_in = mi4_pkg::KIND_DET;
                  end
                  idx_in = idx_ff + 4'd1;
               end
               default: begin
                  det_in = acc_ff;
                  idx_in = 4'd0;
               end
            endcase
         end
         mi4_pkg::ST_DPREP: begin
            dneg_in     = det_ff[AW-1];
            dmag_in     = det_ff[AW-1] ? (~det_ff + 1'b1) : det_ff;
            singular_in = (det_ff == '0);
         end
         mi4_pkg::ST_DRND: begin
            det_clip_in = det_round > det_lim;
            det_out_in  = det_clip_in ? lim_det : det_round[W-1:0];
            if (dneg_ff) begin
               det_out_in = ~det_out_in + 1'b1;
            end
         end
         mi4_pkg::ST_DLD: begin
            qneg_in = work_rdata[CW-1] ^ dneg_ff;
            rem_in  = ({{(RW - CW){1'b0}}, cof_mag} << NSH) + {{(RW - AW){1'b0}}, dmag_ff};
         end
         mi4_pkg::ST_DCHK: begin
            ovf_in  = ovf_now;
            dsh_in  = {{(RW - AW){1'b0}}, dmag_ff} << W;
            q_in    = '0;
            bcnt_in = BCW'(W - 1);
         end
         mi4_pkg::ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in    = {q_ff[W-2:0], rem_ff >= dsh_ff};
            dsh_in  = dsh_ff >> 1;
            bcnt_in = bcnt_ff - 1'b1;
         end
         mi4_pkg::ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in     = 1'b1;
               rsp_inverse_in   = singular_ff ? '0 : val_q;
               rsp_index_in     = idx_ff;
               rsp_det_in       = det_out_ff;
               rsp_singular_in  = singular_ff;
               rsp_saturated_in = det_clip_ff || (!singular_ff && clip_q);
               rsp_last_in      = (idx_ff == mi4_pkg::LAST_INDEX);
               idx_in           = idx_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mi4_pkg::ST_LOAD;
         load_count_ff <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      idx_ff           <= idx_in;
      term_ff          <= term_in;
      dcnt_ff          <= dcnt_in;
      emag_ff          <= emag_in;
      esign_ff         <= esign_in;
      vmag_ff          <= vmag_in;
      vsign_ff         <= vsign_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      det_ff           <= det_in;
      dmag_ff          <= dmag_in;
      dneg_ff          <= dneg_in;
      singular_ff      <= singular_in;
      det_out_ff       <= det_out_in;
      det_clip_ff      <= det_clip_in;
      rem_ff           <= rem_in;
      dsh_ff           <= dsh_in;
      q_ff             <= q_in;
      bcnt_ff          <= bcnt_in;
      ovf_ff           <= ovf_in;
      qneg_ff          <= qneg_in;
      rsp_inverse_ff   <= rsp_inverse_in;
      rsp_index_ff     <= rsp_index_in;
      rsp_det_ff       <= rsp_det_in;
      rsp_singular_ff  <= rsp_singular_in;
      rsp_saturated_ff <= rsp_saturated_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inverse_value = rsp_inverse_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_determinant   = rsp_det_ff;
   assign rsp_singular      = rsp_singular_ff;
   assign rsp_saturated     = rsp_saturated_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== dv/tb_matrix_inverse_4x4.sv =====
// tb_matrix_inverse_4x4: self-checking testbench for the 4x4 fixed-point matrix inverse.
// Depends on mi4_pkg and matrix_inverse_4x4; predicts every inverse entry with
// wide exact arithmetic and compares each rsp transaction in order.
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4;

   localparam int VW = mi4_pkg::VALUE_WIDTH_DEF;
   localparam int FB = mi4_pkg::FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_LIMIT = 100000;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [VW-1:0] inverse_value;
      logic [3:0]    element_index;
      logic [VW-1:0] determinant;
      logic          singular;
      logic          saturated;
      logic          last;
   } entry_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [VW-1:0] req_element_value = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [VW-1:0] rsp_inverse_value;
   logic [3:0]    rsp_element_index;
   logic [VW-1:0] rsp_determinant;
   logic          rsp_singular;
   logic          rsp_saturated;
   logic          rsp_last;

   logic signed [VW-1:0] loaded_matrix[16];
   logic [3:0]           load_index = '0;
   entry_type            pending_entries[$];
   int                   error_count = 0;
   int                   idle_cycles = 0;
   int                   rsp_hold = 0;
   bit                   long_hold = 1'b0;
   bit                   quiet_send = 1'b0;
   bit                   quiet_recv = 1'b0;

   matrix_inverse_4x4 dut (.*);

   always #10 clock = ~clock;

   // exact 3x3 minor of the loaded matrix with checkerboard sign
   function automatic wide_type cofactor_of(int row, int col);
      wide_type e[9];
      wide_type m;
      int       k;
      k = 0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (i != row && j != col) begin
               e[k] = loaded_matrix[i * 4 + j];
               k++;
            end
         end
      end
      m = e[0] * (e[4] * e[8] - e[5] * e[7]) - e[1] * (e[3] * e[8] - e[5] * e[6])
          + e[2] * (e[3] * e[7] - e[4] * e[6]);
      return ((row + col) % 2) ? -m : m;
   endfunction

   // returns {clipped, value}
   function automatic logic [VW:0] saturate_q(wide_type mag, bit neg);
      wide_type lim;
      wide_type v;
      bit       clip;
      lim = (wide_type'(1) <<< (VW - 1)) - (neg ? 0 : 1);
      clip = (mag > lim);
      v = clip ? lim : mag;
      if (neg) v = -v;
      return {clip, v[VW-1:0]};
   endfunction

   task automatic predict_inverse();
      wide_type      cof[16];
      wide_type      det;
      wide_type      dmag;
      wide_type      num;
      logic [VW:0]   dsat;
      logic [VW:0]   esat;
      bit            sing;
      entry_type     ent;
      det = 0;
      for (int i = 0; i < 16; i++) cof[i] = cofactor_of(i / 4, i % 4);
      for (int j = 0; j < 4; j++) det += wide_type'(loaded_matrix[j]) * cof[j];
      sing = (det == 0);
      dmag = (det < 0) ? -det : det;
      dsat = saturate_q((dmag + (wide_type'(1) <<< (3 * FB - 1))) >>> (3 * FB), det < 0);
      for (int i = 0; i < 16; i++) begin
         esat = '0;
         if (!sing) begin
            wide_type c;
            c = cof[(i % 4) * 4 + i / 4];
            num = (((c < 0) ? -c : c) <<< (2 * FB + 1)) + dmag;
            esat = saturate_q(num / (dmag <<< 1), (c < 0) != (det < 0));
         end
         ent.inverse_value = esat[VW-1:0];
         ent.element_index = 4'(i);
         ent.determinant   = dsat[VW-1:0];
         ent.singular      = sing;
         ent.saturated     = esat[VW] | dsat[VW];
         ent.last          = (i == 15);
         pending_entries.push_back(ent);
      end
   endtask

   task automatic send_element(logic [VW-1:0] value);
      int gap;
      req_valid <= 1'b1;
      req_element_value <= value;
      do @(posedge clock); while (req_stall);
      loaded_matrix[load_index] = value;
      if (load_index == mi4_pkg::LAST_INDEX) predict_inverse();
      load_index = load_index + 4'd1;
      gap = quiet_send ? 0 : (($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60)));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_matrix(logic [VW-1:0] m[16]);
      for (int i = 0; i < 16; i++) send_element(m[i]);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_entries.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= DRAIN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   endtask

   task automatic hold_receiver(int cycles);
      long_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      long_hold = 1'b0;
   endtask

   always @(posedge clock) begin
      entry_type exp_e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_entries.size() == 0) begin
               $error("unexpected transaction, inverse_value %h", rsp_inverse_value);
               error_count++;
            end else begin
               exp_e = pending_entries.pop_front();
               if (rsp_inverse_value !== exp_e.inverse_value) begin
                  $error("inverse_value exp %h got %h", exp_e.inverse_value, rsp_inverse_value);
                  error_count++;
               end
               if (rsp_element_index !== exp_e.element_index) begin
                  $error("element_index exp %0d got %0d", exp_e.element_index,
                         rsp_element_index);
                  error_count++;
               end
               if (rsp_determinant !== exp_e.determinant) begin
                  $error("determinant exp %h got %h", exp_e.determinant, rsp_determinant);
                  error_count++;
               end
               if (rsp_singular !== exp_e.singular) begin
                  $error("singular exp %b got %b", exp_e.singular, rsp_singular);
                  error_count++;
               end
               if (rsp_saturated !== exp_e.saturated) begin
                  $error("saturated exp %b got %b", exp_e.saturated, rsp_saturated);
                  error_count++;
               end
               if (rsp_last !== exp_e.last) begin
                  $error("last exp %b got %b", exp_e.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold <= rsp_hold - 1;
         end else if (quiet_recv) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 99) == 0) rsp_hold <= $urandom_range(20, 80);
         end
      end
   end

   function automatic logic [VW-1:0] fx(int units);
      return VW'(units) << FB;
   endfunction

   task automatic test_identity();
      logic [VW-1:0] m[16];
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? fx(1) : '0;
      send_matrix(m);
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? fx(i / 5 + 2) : fx(i % 3) >>> 2;
      send_matrix(m);
   endtask

   task automatic test_singular();
      logic [VW-1:0] m[16];
      for (int i = 0; i < 16; i++) m[i] = '0;
      send_matrix(m);
      for (int i = 0; i < 16; i++) m[i] = fx(i + 1);
      send_matrix(m);
   endtask

   task automatic test_extremes();
      logic [VW-1:0] m[16];
      for (int i = 0; i < 16; i++) m[i] = '0;
      m[0] = 32'h7fff_ffff; m[5] = 32'h8000_0000; m[10] = 32'hffff_ffff; m[15] = 32'h1;
      m[3] = 32'h8000_0000; m[12] = 32'h7fff_ffff;
      send_matrix(m);
   endtask

   // exact determinant nonzero but its rounded output is zero
   task automatic test_tiny_determinant();
      logic [VW-1:0] m[16];
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h100 : '0;
      m[1] = 32'h3;
      send_matrix(m);
   endtask

   task automatic send_random_matrix();
      logic [VW-1:0] m[16];
      int kind;
      kind = $urandom_range(0, 19);
      for (int i = 0; i < 16; i++) begin
         if (kind < 10) begin
            m[i] = VW'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
            if (i % 5 == 0) m[i] = m[i] + fx(2);
         end else if (kind < 15) begin
            m[i] = $urandom();
         end else if (kind < 18) begin
            m[i] = fx($urandom_range(0, 6) - 3);
         end else begin
            m[i] = VW'($signed($urandom_range(0, 1024)) - 512);
         end
      end
      send_matrix(m);
   endtask

   task automatic test_backpressure();
      quiet_send = 1'b1;
      fork
         hold_receiver(3000);
      join_none
      send_random_matrix();
      send_random_matrix();
      quiet_send = 1'b0;
      wait_drained();
   endtask

   task automatic test_drain_pause();
      quiet_recv = 1'b1;
      send_random_matrix();
      wait_drained();
      quiet_recv = 1'b0;
      send_random_matrix();
   endtask

   task automatic test_random(int matrices);
      for (int n = 0; n < matrices; n++) begin
         quiet_send = (n % 6 == 3);
         send_random_matrix();
      end
      quiet_send = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_identity();
      test_singular();
      test_extremes();
      test_tiny_determinant();
      test_backpressure();
      test_drain_pause();
      test_random(13);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_entries.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
